### rtl/edfs_pkg.sv
// ----------------------------------------------------------------------------
// EDF scheduler package
// Command and status codes, the slot write request, the result flags and the
// wrapping deadline adder shared by the scheduler modules.
// ----------------------------------------------------------------------------
package edfs_pkg;

  // Width of deadlines, periods and the time counter.
  localparam int unsigned DL_W     = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;

  // Command codes of an input item.
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STOP   = 2'd3;

  // Status codes of a result item.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_TASK = 2'd2;

  // Write request into the slot memories.
  typedef struct packed {
    logic            dl_we;
    logic            per_we;
    logic [DL_W-1:0] deadline;
    logic [DL_W-1:0] period;
  } edfs_wr_t;

  // Flags of a finished item.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                switched;
  } edfs_res_t;

  // Modulo 2^32 sum where an all-ones result folds to zero.
  function automatic logic [DL_W-1:0] wrap_add(input logic [DL_W-1:0] a,
                                               input logic [DL_W-1:0] b);
    logic [DL_W-1:0] sum;
    sum = a + b;
    return (sum == '1) ? '0 : sum;
  endfunction

endpackage

### rtl/edfs_slot_ram.sv
// ----------------------------------------------------------------------------
// EDF scheduler slot memory
// Deadline and period of every task slot in two synchronous memories that
// share one read address and one write address; read data is registered.
// ----------------------------------------------------------------------------
module edfs_slot_ram #(
  parameter int unsigned TASK_SLOTS = 8,
  localparam int unsigned SlotW = $clog2(TASK_SLOTS)
) (
  input  logic                           clk_i,
  input  logic [SlotW-1:0]               rd_addr_i,
  input  logic [SlotW-1:0]               wr_addr_i,
  input  edfs_pkg::edfs_wr_t             wr_i,
  output logic [edfs_pkg::DL_W-1:0]      rd_dl_o,
  output logic [edfs_pkg::DL_W-1:0]      rd_per_o
);
  import edfs_pkg::*;

  logic [DL_W-1:0] dl_mem  [TASK_SLOTS];
  logic [DL_W-1:0] per_mem [TASK_SLOTS];
  logic [DL_W-1:0] rd_dl_q;
  logic [DL_W-1:0] rd_per_q;

  // Write port and registered read port of both memories.
  always_ff @(posedge clk_i) begin
    if (wr_i.dl_we) begin
      dl_mem[wr_addr_i] <= wr_i.deadline;
    end
    if (wr_i.per_we) begin
      per_mem[wr_addr_i] <= wr_i.period;
    end
    rd_dl_q  <= dl_mem[rd_addr_i];
    rd_per_q <= per_mem[rd_addr_i];
  end

  assign rd_dl_o  = rd_dl_q;
  assign rd_per_o = rd_per_q;

endmodule

### rtl/edfs_ctrl.sv
// ----------------------------------------------------------------------------
// EDF scheduler control
// Sequencer that executes one command at a time by sweeping the slot memory
// one slot per cycle, keeping the slot occupancy, the running task and time.
// ----------------------------------------------------------------------------
module edfs_ctrl #(
  parameter int unsigned TASK_SLOTS = 8,
  localparam int unsigned SlotW = $clog2(TASK_SLOTS)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Command side.
  input  logic                           start_i,
  input  logic [edfs_pkg::CMD_W-1:0]     cmd_i,
  input  logic [edfs_pkg::DL_W-1:0]      period_i,
  input  logic [edfs_pkg::DL_W-1:0]      first_i,
  output logic                           idle_o,
  // Result side.
  output logic                           res_valid_o,
  input  logic                           res_take_i,
  output edfs_pkg::edfs_res_t            res_o,
  output logic [SlotW-1:0]               cur_o,
  output logic                           run_o,
  output logic [SlotW-1:0]               new_slot_o,
  // Slot memory.
  output logic [SlotW-1:0]               rd_addr_o,
  input  logic [edfs_pkg::DL_W-1:0]      rd_dl_i,
  input  logic [edfs_pkg::DL_W-1:0]      rd_per_i,
  output logic [SlotW-1:0]               wr_addr_o,
  output edfs_pkg::edfs_wr_t             wr_o
);
  import edfs_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_RDCUR   = 3'd1;
  localparam logic [2:0] ST_CURDATA = 3'd2;
  localparam logic [2:0] ST_SCAN    = 3'd3;
  localparam logic [2:0] ST_FIN     = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;

  // Sweep kinds.
  localparam logic [1:0] SM_FREE  = 2'd0;  // first free slot for create
  localparam logic [1:0] SM_MIN   = 2'd1;  // earliest live slot for start
  localparam logic [1:0] SM_FLAG  = 2'd2;  // any live deadline earlier than the running one
  localparam logic [1:0] SM_RESCH = 2'd3;  // reschedule with deadline advance

  localparam logic [SlotW-1:0] LastSlot = SlotW'(TASK_SLOTS - 1);

  logic [2:0]            state_q, state_d;
  logic [1:0]            smode_q, smode_d;
  logic [SlotW-1:0]      idx_q, idx_d;
  logic [SlotW-1:0]      pidx_q, pidx_d;
  logic                  iss_q, iss_d;
  logic                  pv_q, pv_d;
  logic [TASK_SLOTS-1:0] live_q, live_d;
  logic                  run_q, run_d;
  logic [SlotW-1:0]      cur_q, cur_d;
  logic [DL_W-1:0]       t_q, t_d;
  logic                  have_q, have_d;
  logic                  flag_q, flag_d;
  logic [SlotW-1:0]      next_q, next_d;
  logic [DL_W-1:0]       cd_q, cd_d;
  logic [DL_W-1:0]       best_q, best_d;
  logic [DL_W-1:0]       bestp_q, bestp_d;
  logic [DL_W-1:0]       per_q, per_d;
  logic [DL_W-1:0]       first_q, first_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic                  sw_q, sw_d;
  logic [SlotW-1:0]      new_q, new_d;

  logic                  slot_live;
  logic                  slot_ready;
  logic                  dl_less;
  logic                  dl_hit;
  logic [DL_W-1:0]       dl_adv;
  logic                  last_issue;
  logic                  last_data;

  // Per-slot terms of the item coming back from memory.
  assign slot_live  = live_q[pidx_q];
  assign slot_ready = slot_live && !(run_q && (pidx_q == cur_q));
  assign dl_less    = rd_dl_i < best_q;
  assign dl_hit     = rd_dl_i == t_q;
  assign dl_adv     = wrap_add(rd_dl_i, rd_per_i);
  assign last_issue = idx_q == LastSlot;
  assign last_data  = pv_q && (pidx_q == LastSlot);

  // Next-state logic of the sequencer and the sweep.
  always_comb begin
    state_d  = state_q;
    smode_d  = smode_q;
    idx_d    = idx_q;
    pidx_d   = pidx_q;
    iss_d    = iss_q;
    pv_d     = pv_q;
    live_d   = live_q;
    run_d    = run_q;
    cur_d    = cur_q;
    t_d      = t_q;
    have_d   = have_q;
    flag_d   = flag_q;
    next_d   = next_q;
    cd_d     = cd_q;
    best_d   = best_q;
    bestp_d  = bestp_q;
    per_d    = per_q;
    first_d  = first_q;
    status_d = status_q;
    sw_d     = sw_q;
    new_d    = new_q;
    rd_addr_o = idx_q;
    wr_addr_o = pidx_q;
    wr_o      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          status_d = STATUS_OK;
          sw_d     = 1'b0;
          new_d    = '0;
          per_d    = period_i;
          first_d  = first_i;
          have_d   = 1'b0;
          idx_d    = '0;
          iss_d    = 1'b1;
          pv_d     = 1'b0;
          unique case (cmd_i)
            CMD_TICK: begin
              t_d     = wrap_add(t_q, DL_W'(1));
              state_d = run_q ? ST_RDCUR : ST_DONE;
            end
            CMD_CREATE: begin
              smode_d = SM_FREE;
              state_d = ST_SCAN;
            end
            CMD_START: begin
              smode_d = SM_MIN;
              state_d = ST_SCAN;
            end
            CMD_STOP: begin
              // The running task is released and its slot becomes free.
              if (run_q) begin
                live_d[cur_q] = 1'b0;
                run_d   = 1'b0;
                sw_d    = 1'b1;
                smode_d = SM_RESCH;
                state_d = ST_SCAN;
              end else begin
                state_d = ST_DONE;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end

      ST_RDCUR: begin
        rd_addr_o = cur_q;
        state_d   = ST_CURDATA;
      end

      ST_CURDATA: begin
        // Running deadline reached: advance it and reschedule right away; otherwise look for an earlier live task.
        cd_d  = rd_dl_i;
        idx_d = '0;
        iss_d = 1'b1;
        pv_d  = 1'b0;
        state_d = ST_SCAN;
        if (dl_hit) begin
          wr_o.dl_we    = 1'b1;
          wr_o.deadline = dl_adv;
          wr_addr_o     = cur_q;
          best_d  = dl_adv;
          have_d  = 1'b1;
          next_d  = cur_q;
          smode_d = SM_RESCH;
        end else begin
          best_d  = rd_dl_i;
          flag_d  = 1'b0;
          smode_d = SM_FLAG;
        end
      end

      ST_SCAN: begin
        // Issue one read a cycle; evaluate the slot whose read was issued in the previous cycle.
        pv_d   = iss_q;
        pidx_d = idx_q;
        if (iss_q) begin
          if (last_issue) begin
            iss_d = 1'b0;
          end else begin
            idx_d = idx_q + SlotW'(1);
          end
        end
        if (pv_q) begin
          unique case (smode_q)
            SM_FREE: begin
              if (!slot_live && !have_q) begin
                have_d = 1'b1;
                next_d = pidx_q;
              end
            end
            SM_MIN: begin
              if (slot_live && (!have_q || dl_less)) begin
                have_d  = 1'b1;
                best_d  = rd_dl_i;
                bestp_d = rd_per_i;
                next_d  = pidx_q;
              end
            end
            SM_FLAG: begin
              if (slot_live && (rd_dl_i < cd_q)) begin
                flag_d = 1'b1;
              end
            end
            SM_RESCH: begin
              if (slot_ready) begin
                if (!have_q || dl_less) begin
                  have_d = 1'b1;
                  best_d = rd_dl_i;
                  next_d = pidx_q;
                end
                // A ready task whose deadline is now gets its next period.
                if (dl_hit) begin
                  wr_o.dl_we    = 1'b1;
                  wr_o.deadline = dl_adv;
                end
              end
            end
            default: ;
          endcase
        end
        if (last_data) begin
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        state_d = ST_DONE;
        unique case (smode_q)
          SM_FREE: begin
            if (have_q) begin
              wr_o.dl_we    = 1'b1;
              wr_o.per_we   = 1'b1;
              wr_o.deadline = first_q;
              wr_o.period   = per_q;
              wr_addr_o     = next_q;
              live_d[next_q] = 1'b1;
              new_d = next_q;
            end else begin
              status_d = STATUS_FULL;
            end
          end
          SM_MIN: begin
            if (!have_q) begin
              status_d = STATUS_NO_TASK;
            end else begin
              wr_o.dl_we    = 1'b1;
              wr_o.deadline = wrap_add(best_q, bestp_q);
              wr_addr_o     = next_q;
              run_d = 1'b1;
              cur_d = next_q;
              sw_d  = !run_q || (next_q != cur_q);
            end
          end
          SM_FLAG: begin
            // Some live task is earlier than the running one: reschedule.
            if (flag_q) begin
              smode_d = SM_RESCH;
              have_d  = 1'b1;
              next_d  = cur_q;
              idx_d   = '0;
              iss_d   = 1'b1;
              pv_d    = 1'b0;
              state_d = ST_SCAN;
            end
          end
          SM_RESCH: begin
            if (have_q && ((next_q != cur_q) || !run_q)) begin
              run_d = 1'b1;
              cur_d = next_q;
              sw_d  = 1'b1;
            end
          end
          default: ;
        endcase
      end

      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      smode_q <= SM_FREE;
      idx_q   <= '0;
      pidx_q  <= '0;
      iss_q   <= 1'b0;
      pv_q    <= 1'b0;
      live_q  <= '0;
      run_q   <= 1'b0;
      cur_q   <= '0;
      t_q     <= '0;
      have_q  <= 1'b0;
      flag_q  <= 1'b0;
      next_q  <= '0;
    end else begin
      state_q <= state_d;
      smode_q <= smode_d;
      idx_q   <= idx_d;
      pidx_q  <= pidx_d;
      iss_q   <= iss_d;
      pv_q    <= pv_d;
      live_q  <= live_d;
      run_q   <= run_d;
      cur_q   <= cur_d;
      t_q     <= t_d;
      have_q  <= have_d;
      flag_q  <= flag_d;
      next_q  <= next_d;
    end
  end

  // Working values of the current item.
  always_ff @(posedge clk_i) begin
    cd_q     <= cd_d;
    best_q   <= best_d;
    bestp_q  <= bestp_d;
    per_q    <= per_d;
    first_q  <= first_d;
    status_q <= status_d;
    sw_q     <= sw_d;
    new_q    <= new_d;
  end

  assign idle_o       = state_q == ST_IDLE;
  assign res_valid_o  = state_q == ST_DONE;
  assign res_o.status   = status_q;
  assign res_o.switched = sw_q;
  assign cur_o        = cur_q;
  assign run_o        = run_q;
  assign new_slot_o   = new_q;

endmodule

### rtl/edf_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// EDF task scheduler unit
// Earliest-deadline-first scheduler over a table of task slots with tick,
// create, start and stop commands and one result item per command.
// ----------------------------------------------------------------------------
// One command is executed at a time, and every command that looks at the
// table walks it through the deadline and period memories, one slot per
// cycle. A tick with no running task, and a stop with nothing running, go
// straight to the result without a sweep; create, start and stop make one
// sweep; a tick with a running task first reads the running slot and then
// sweeps, and sweeps a second time to reschedule when an earlier live task
// calls for it. The next item is accepted once the previous result has
// moved to the output register, so a waiting result does not hold up the next
// command. Memory contents need no clearing after reset.
module edf_task_scheduler_unit #(
  parameter int unsigned TASK_SLOTS = 8,
  localparam int unsigned SlotW = $clog2(TASK_SLOTS)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input items.
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [edfs_pkg::CMD_W-1:0]      cmd_i,
  input  logic [edfs_pkg::DL_W-1:0]       task_period_i,
  input  logic [edfs_pkg::DL_W-1:0]       first_deadline_i,
  // Result items.
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [edfs_pkg::STATUS_W-1:0]   status_o,
  output logic [SlotW-1:0]                running_task_o,
  output logic                            running_valid_o,
  output logic                            switched_o,
  output logic [SlotW-1:0]                new_slot_o
);
  import edfs_pkg::*;

  logic                idle;
  logic                res_valid;
  logic                res_take;
  edfs_res_t           res;
  logic [SlotW-1:0]    cur;
  logic                run;
  logic [SlotW-1:0]    new_slot;
  logic [SlotW-1:0]    rd_addr;
  logic [SlotW-1:0]    wr_addr;
  edfs_wr_t            wr;
  logic [DL_W-1:0]     rd_dl;
  logic [DL_W-1:0]     rd_per;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q;
  logic [SlotW-1:0]    running_task_q;
  logic                running_valid_q;
  logic                switched_q;
  logic [SlotW-1:0]    new_slot_q;

  assign in_stall_o = !idle;

  edfs_slot_ram #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_i      (wr),
    .rd_dl_o   (rd_dl),
    .rd_per_o  (rd_per)
  );

  edfs_ctrl #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i && idle),
    .cmd_i       (cmd_i),
    .period_i    (task_period_i),
    .first_i     (first_deadline_i),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .cur_o       (cur),
    .run_o       (run),
    .new_slot_o  (new_slot),
    .rd_addr_o   (rd_addr),
    .rd_dl_i     (rd_dl),
    .rd_per_i    (rd_per),
    .wr_addr_o   (wr_addr),
    .wr_o        (wr)
  );

  // Output register: loads a finished item when empty or being drained.
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      status_q        <= res.status;
      running_task_q  <= cur;
      running_valid_q <= run;
      switched_q      <= res.switched;
      new_slot_q      <= new_slot;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign running_task_o  = running_task_q;
  assign running_valid_o = running_valid_q;
  assign switched_o      = switched_q;
  assign new_slot_o      = new_slot_q;

endmodule
